FILE: src/snz_pkg.sv
package snz_pkg;

  localparam int TABLE_DEPTH     = 256;
  localparam int ADDR_W          = $clog2(TABLE_DEPTH);
  localparam int COORD_FRAC_BITS = 16;
  localparam int Q24_BITS        = 24;
  localparam int X0_SHIFT        = Q24_BITS - COORD_FRAC_BITS;

  localparam int CRD_W   = 32;
  localparam int WORD_W  = 31;
  localparam int OUT_W   = 18;
  localparam int OUT_MAX = 65536;

  localparam int IN_FIELDS_W  = 4 * CRD_W + ADDR_W + WORD_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

  localparam int K_W     = 30;
  localparam int SUM_W   = CRD_W + 2;
  localparam int PROD_W  = SUM_W + K_W;
  localparam int CELL_W  = SUM_W + 1 - COORD_FRAC_BITS;
  localparam int SCELL_W = CELL_W + 2;
  localparam int TPROD_W = SCELL_W + K_W + 1;
  localparam int X0_W    = 32;
  localparam int HKEY_W  = 32;
  localparam int POS_W   = X0_W + 1;
  localparam int DOT_W   = POS_W + 2;
  localparam int MUL_W   = DOT_W;
  localparam int MP_W    = 2 * MUL_W;
  localparam int D2_W    = 2 * POS_W + 2;
  localparam int T_W     = Q24_BITS;
  localparam int CG_W    = Q24_BITS;
  localparam int TOT_W   = 40;
  localparam int SCALE_W = 7;
  localparam int FIN_W   = TOT_W + SCALE_W + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_2D   = 2'd1,
    CMD_3D   = 2'd2,
    CMD_4D   = 2'd3
  } cmd_t;

  localparam logic [K_W-1:0] SKEW_Q30 [3] = '{30'd393016785, 30'd357913941, 30'd331804471};
  localparam logic [K_W-1:0] UNSKEW_Q30 [3] = '{30'd226908346, 30'd178956971, 30'd148387471};
  localparam logic [T_W-1:0] RADIUS_Q24 [3] = '{24'd8388608, 24'd10066330, 24'd10066330};
  localparam logic [SCALE_W-1:0] OUT_SCALE [3] = '{7'd70, 7'd32, 7'd27};
  localparam logic [CG_W-1:0] GSTEP_Q24 [3] = '{
    CG_W'((UNSKEW_Q30[0] + 32) >> 6),
    CG_W'((UNSKEW_Q30[1] + 32) >> 6),
    CG_W'((UNSKEW_Q30[2] + 32) >> 6)
  };
  localparam logic [POS_W-1:0] ONE_Q24 = POS_W'(1) << Q24_BITS;

  localparam logic signed [1:0] GP = 2'sb01;
  localparam logic signed [1:0] GN = 2'sb11;
  localparam logic signed [1:0] GZ = 2'sb00;

  localparam logic signed [1:0] GRAD3 [12][3] = '{
    '{GP,GP,GZ}, '{GN,GP,GZ}, '{GP,GN,GZ}, '{GN,GN,GZ},
    '{GP,GZ,GP}, '{GN,GZ,GP}, '{GP,GZ,GN}, '{GN,GZ,GN},
    '{GZ,GP,GP}, '{GZ,GN,GP}, '{GZ,GP,GN}, '{GZ,GN,GN}
  };

  localparam logic signed [1:0] GRAD4 [32][4] = '{
    '{GZ,GP,GP,GP}, '{GZ,GP,GP,GN}, '{GZ,GP,GN,GP}, '{GZ,GP,GN,GN},
    '{GZ,GN,GP,GP}, '{GZ,GN,GP,GN}, '{GZ,GN,GN,GP}, '{GZ,GN,GN,GN},
    '{GP,GZ,GP,GP}, '{GP,GZ,GP,GN}, '{GP,GZ,GN,GP}, '{GP,GZ,GN,GN},
    '{GN,GZ,GP,GP}, '{GN,GZ,GP,GN}, '{GN,GZ,GN,GP}, '{GN,GZ,GN,GN},
    '{GP,GP,GZ,GP}, '{GP,GP,GZ,GN}, '{GP,GN,GZ,GP}, '{GP,GN,GZ,GN},
    '{GN,GP,GZ,GP}, '{GN,GP,GZ,GN}, '{GN,GN,GZ,GP}, '{GN,GN,GZ,GN},
    '{GP,GP,GP,GZ}, '{GP,GP,GN,GZ}, '{GP,GN,GP,GZ}, '{GP,GN,GN,GZ},
    '{GN,GP,GP,GZ}, '{GN,GP,GN,GZ}, '{GN,GN,GP,GZ}, '{GN,GN,GN,GZ}
  };

  typedef struct packed {
    cmd_t                         cmd;
    logic [3:0][HKEY_W-1:0]       lattice;
    logic [3:0][X0_W-1:0]         x0;
    logic [3:0][2:0]              rank;
    logic [ADDR_W-1:0]            idx;
    logic [WORD_W-1:0]            val;
  } qent_t;

  function automatic logic [2:0] dims(input cmd_t cmd);
    return 3'(cmd) + 3'd1;
  endfunction

  function automatic logic [1:0] mode_idx(input cmd_t cmd);
    return (cmd == CMD_LOAD) ? 2'd0 : 2'(cmd) - 2'd1;
  endfunction

  // h mod 12 for an 8-bit h: reciprocal 171/2048 is exact over this range
  function automatic logic [3:0] mod12(input logic [7:0] h);
    logic [15:0] p;
    logic [7:0]  q;
    logic [7:0]  r;
    p = 16'(h) * 16'd171;
    q = 8'(p[15:11]);
    r = h - 8'(q * 8'd12);
    return r[3:0];
  endfunction

  function automatic logic signed [1:0] grad_comp(input logic four, input logic [4:0] gi,
                                                  input logic [1:0] ax);
    if (four) return GRAD4[gi][ax];
    else if (ax == 2'd3) return GZ;
    else return GRAD3[gi[3:0]][ax];
  endfunction

endpackage

FILE: src/snz_front.sv
module snz_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  snz_pkg::cmd_t                    in_cmd,
  input  logic [3:0][snz_pkg::CRD_W-1:0]   in_crd,
  input  logic [snz_pkg::ADDR_W-1:0]       in_idx,
  input  logic [snz_pkg::WORD_W-1:0]       in_val,
  output logic                             out_valid,
  input  logic                             out_ready,
  output snz_pkg::qent_t                   out_ent
);
  import snz_pkg::*;

  typedef struct packed {
    cmd_t                      cmd;
    logic [3:0][CRD_W-1:0]     crd;
    logic [SUM_W-1:0]          sum;
    logic [PROD_W-1:0]         prod;
    logic [3:0][CELL_W-1:0]    lattice;
    logic [SCELL_W-1:0]        scell;
    logic [TPROD_W-1:0]        tprod;
    logic [3:0][X0_W-1:0]      x0;
    logic [ADDR_W-1:0]         idx;
    logic [WORD_W-1:0]         val;
  } fe_t;

  logic [5:0] v;
  fe_t        st [6];
  fe_t        s0n, s1n, s2n, s3n, s4n, s5n;
  logic       en;

  logic [SUM_W-1:0]          sum_c;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [SUM_W-1:0]   s_c;
  logic signed [SUM_W:0]     cs_c;
  logic [SCELL_W-1:0]        scell_c;
  logic signed [TPROD_W-1:0] tprod_c;
  logic signed [63:0]        xa_c;
  logic [3:0][2:0]           rk;
  logic signed [X0_W-1:0]    xa, xb;
  logic                      win;

  // the whole pipe moves unless its last stage is blocked by the queue
  assign en       = !v[5] || out_ready;
  assign in_ready = en;
  assign out_valid = v[5];

  always_comb begin
    // stage 0: mask unused axes, sum the coordinates
    s0n = '0;
    s0n.cmd = in_cmd;
    s0n.idx = in_idx;
    s0n.val = in_val;
    sum_c = '0;
    for (int a = 0; a < 4; a++) begin
      if (3'(a) < dims(in_cmd)) s0n.crd[a] = in_crd[a];
      sum_c = sum_c + SUM_W'($signed(s0n.crd[a]));
    end
    s0n.sum = sum_c;

    // stage 1: skew product
    s1n = st[0];
    prod_c = $signed(st[0].sum) * $signed({1'b0, SKEW_Q30[mode_idx(st[0].cmd)]});
    s1n.prod = prod_c;

    // stage 2: cell by floor
    s2n = st[1];
    s_c = SUM_W'($signed(st[1].prod) >>> K_W);
    for (int a = 0; a < 4; a++) begin
      cs_c = $signed(st[1].crd[a]) + s_c;
      s2n.lattice[a] = cs_c[SUM_W:COORD_FRAC_BITS];
    end

    // stage 3: sum of used cells
    s3n = st[2];
    scell_c = '0;
    for (int a = 0; a < 4; a++)
      if (3'(a) < dims(st[2].cmd)) scell_c = scell_c + SCELL_W'($signed(st[2].lattice[a]));
    s3n.scell = scell_c;

    // stage 4: unskew product
    s4n = st[3];
    tprod_c = $signed(st[3].scell) * $signed({1'b0, UNSKEW_Q30[mode_idx(st[3].cmd)]});
    s4n.tprod = tprod_c;

    // stage 5: in-cell offsets, Q.24
    s5n = st[4];
    for (int a = 0; a < 4; a++) begin
      xa_c = ($signed(st[4].crd[a]) <<< X0_SHIFT) - ($signed(st[4].lattice[a]) <<< Q24_BITS)
             + ($signed(st[4].tprod) >>> 6);
      s5n.x0[a] = xa_c[X0_W-1:0];
    end
  end

  // rank the offsets of the last stage
  always_comb begin
    rk = '0;
    xa = '0;
    xb = '0;
    win = 1'b0;
    for (int a = 0; a < 4; a++)
      for (int b = a + 1; b < 4; b++)
        if (3'(b) < dims(st[5].cmd)) begin
          xa = $signed(st[5].x0[a]);
          xb = $signed(st[5].x0[b]);
          win = (st[5].cmd == CMD_3D) ? (xa >= xb) : (xa > xb);
          if (win) rk[a] = rk[a] + 3'd1;
          else rk[b] = rk[b] + 3'd1;
        end
  end

  always_comb begin
    out_ent.cmd  = st[5].cmd;
    out_ent.x0   = st[5].x0;
    out_ent.rank = rk;
    out_ent.idx  = st[5].idx;
    out_ent.val  = st[5].val;
    for (int a = 0; a < 4; a++)
      out_ent.lattice[a] = HKEY_W'($signed(st[5].lattice[a]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= s0n;
      st[1] <= s1n;
      st[2] <= s2n;
      st[3] <= s3n;
      st[4] <= s4n;
      st[5] <= s5n;
    end
  end

endmodule

FILE: src/snz_queue.sv
module snz_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  snz_pkg::qent_t  in_ent,
  output logic            out_valid,
  input  logic            out_ready,
  output snz_pkg::qent_t  out_ent
);
  import snz_pkg::*;

  qent_t             slot [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   cnt;
  logic              push, pop;

  assign in_ready  = cnt != (QPTR_W + 1)'(QDEPTH);
  assign out_valid = cnt != '0;
  assign out_ent   = slot[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == QPTR_W'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == QPTR_W'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= in_ent;
  end

endmodule

FILE: src/snz_back.sv
module snz_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  snz_pkg::qent_t             in_ent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [snz_pkg::OUT_W-1:0]  out_value
);
  import snz_pkg::*;

  typedef enum logic [3:0] {
    IDLE, KEY, HASH, SQ, SQACC, TT, T2, T2B, T4, T4B, DOT, ACC, FIN1, FIN2
  } state_t;

  state_t state;
  qent_t  ent;

  logic [WORD_W-1:0] tbl [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en, tbl_we;
  logic [ADDR_W-1:0] rd_addr;

  logic [2:0]          c;
  logic [1:0]          a;
  logic [1:0]          bi;
  logic [HKEY_W-1:0]   k, r;
  logic [7:0]          h;
  logic [CG_W-1:0]     cg;
  logic [D2_W-1:0]     d2;
  logic [T_W-1:0]      t;
  logic signed [DOT_W-1:0] dot;
  logic signed [MP_W-1:0]  mp, mul_c, mp_sh;
  logic signed [TOT_W-1:0] total;
  logic signed [FIN_W-1:0] fin, rnd, shr;

  logic [2:0]              n;
  logic [1:0]              m;
  logic [3:0]              step;
  logic signed [POS_W-1:0] pos [4];
  logic signed [POS_W-1:0] xe;
  logic signed [DOT_W-1:0] dotc, pe;
  logic signed [1:0]       gc;
  logic [4:0]              gi;
  logic signed [MUL_W-1:0] opa, opb;
  logic [HKEY_W-1:0]       kk, dword, rnew;
  logic [7:0]              kb, naddr, fold;
  logic                    over, adv;
  logic [OUT_W-1:0]        sat;

  assign n = dims(ent.cmd);
  assign m = mode_idx(ent.cmd);
  assign in_ready = (state == IDLE);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      step[i] = (4'(ent.rank[i]) + 4'(c)) >= 4'(n);
      xe = $signed(ent.x0[i]);
      pos[i] = xe - (step[i] ? ONE_Q24 : '0) + POS_W'(cg);
    end
  end

  // gradient index and dot product with the corner offset
  always_comb begin
    gi = (ent.cmd == CMD_4D) ? h[4:0] : {1'b0, mod12(h)};
    dotc = '0;
    pe = '0;
    gc = GZ;
    for (int i = 0; i < 4; i++)
      if (3'(i) < n) begin
        gc = grad_comp(ent.cmd == CMD_4D, gi, 2'(i));
        pe = pos[i];
        if (gc == GP) dotc = dotc + pe;
        else if (gc == GN) dotc = dotc - pe;
      end
  end

  // hash chain: at most one table read a cycle
  always_comb begin
    kk = ent.lattice[a] + HKEY_W'(step[a]) + HKEY_W'(h);
    dword = HKEY_W'(rd_data);
    rnew = (bi == 2'd0) ? dword : r + dword;
    unique case (bi)
      2'd0: kb = k[15:8];
      2'd1: kb = k[23:16];
      default: kb = k[31:24];
    endcase
    naddr = kb + rnew[7:0];
    fold = rnew[7:0] + rnew[15:8] + rnew[23:16] + rnew[31:24];
    rd_en = (state == KEY) || (state == HASH && bi != 2'd3);
    rd_addr = (state == KEY) ? kk[ADDR_W-1:0] : naddr[ADDR_W-1:0];
    tbl_we = (state == IDLE) && in_valid && (in_ent.cmd == CMD_LOAD);
  end

  // shared multiplier
  always_comb begin
    unique case (state)
      SQ: begin
        opa = pos[a];
        opb = pos[a];
      end
      DOT: begin
        opa = MUL_W'(t);
        opb = dot;
      end
      default: begin
        opa = MUL_W'(t);
        opb = MUL_W'(t);
      end
    endcase
    mul_c = opa * opb;
    mp_sh = mp >>> Q24_BITS;
  end

  always_comb begin
    over = d2[D2_W-1:Q24_BITS] > (D2_W - Q24_BITS)'(RADIUS_Q24[m]);
    adv = (state == TT && over) || (state == ACC);
    rnd = fin + FIN_W'(128);
    shr = rnd >>> 8;
    if (shr > $signed(FIN_W'(OUT_MAX))) sat = OUT_W'(OUT_MAX);
    else if (shr < -$signed(FIN_W'(OUT_MAX))) sat = OUT_W'(-OUT_MAX);
    else sat = shr[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[in_ent.idx] <= in_ent.val;
    if (rd_en) rd_data <= tbl[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != FIN2) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_valid && in_ent.cmd != CMD_LOAD) begin
            ent   <= in_ent;
            c     <= '0;
            cg    <= '0;
            total <= '0;
            h     <= '0;
            a     <= 2'(dims(in_ent.cmd) - 3'd1);
            state <= KEY;
          end
        end
        KEY: begin
          k     <= kk;
          bi    <= '0;
          state <= HASH;
        end
        HASH: begin
          r <= rnew;
          if (bi != 2'd3) begin
            bi <= bi + 2'd1;
          end else begin
            h <= fold;
            if (a == 2'd0) begin
              d2    <= '0;
              state <= SQ;
            end else begin
              a     <= a - 2'd1;
              state <= KEY;
            end
          end
        end
        SQ: begin
          mp    <= mul_c;
          state <= SQACC;
        end
        SQACC: begin
          d2 <= d2 + D2_W'(mp);
          if ({1'b0, a} == n - 3'd1) begin
            state <= TT;
          end else begin
            a     <= a + 2'd1;
            state <= SQ;
          end
        end
        TT: begin
          if (!over) begin
            t     <= RADIUS_Q24[m] - d2[Q24_BITS +: T_W];
            dot   <= dotc;
            state <= T2;
          end
        end
        T2: begin
          mp    <= mul_c;
          state <= T2B;
        end
        T2B: begin
          t     <= mp[Q24_BITS +: T_W];
          state <= T4;
        end
        T4: begin
          mp    <= mul_c;
          state <= T4B;
        end
        T4B: begin
          t     <= mp[Q24_BITS +: T_W];
          state <= DOT;
        end
        DOT: begin
          mp    <= mul_c;
          state <= ACC;
        end
        ACC: begin
          total <= total + TOT_W'(mp_sh);
        end
        FIN1: begin
          fin   <= total * $signed({1'b0, OUT_SCALE[m]});
          state <= FIN2;
        end
        FIN2: begin
          if (!out_valid || out_ready) begin
            out_value <= sat;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      // advance to the next corner, or finish after the last one
      if (adv) begin
        if (c == n) begin
          state <= FIN1;
        end else begin
          c     <= c + 3'd1;
          cg    <= cg + GSTEP_Q24[m];
          h     <= '0;
          a     <= 2'(n - 3'd1);
          state <= KEY;
        end
      end
    end
  end

endmodule

FILE: src/simplex_noise_2d_3d_4d_top.sv
// Channel  Dir  Bus                                   Word
// s_axis   in   tdata 168 b, tuser 2 b, tvalid/tready  one load or one noise request
// m_axis   out  tdata 24 b, tvalid/tready              one noise sample, Q1.16
//
// Work: a load is one table write in the sequencer; a noise item of n dimensions walks
//   n+1 corners, each with a hash chain on the single-port hash table, at most one read
//   a cycle, and the shared falloff multiplier; no new item is taken until it is done.
//   The front pipeline keeps accepting during that work until the queue fills.
// Reset: synchronous, active high; clears pipeline valids, queue and sequencer.
// Stalls: the two-entry queue lets the front fill while the sequencer or m_axis stalls.
module simplex_noise_2d_3d_4d_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // coord_x, coord_y, coord_z, coord_w, entry_index, entry_value, zero pad
  input  logic [snz_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // noise_value, zero pad
  output logic [snz_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import snz_pkg::*;

  logic             fq_valid, fq_ready;
  qent_t            fq_ent;
  logic             qb_valid, qb_ready;
  qent_t            qb_ent;
  logic [OUT_W-1:0] noise_value;

  // front: skew, floor, unskew and rank in a stall-together pipeline
  snz_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (cmd_t'(s_axis_tuser)),
    .in_crd    (s_axis_tdata[4*CRD_W-1:0]),
    .in_idx    (s_axis_tdata[4*CRD_W +: ADDR_W]),
    .in_val    (s_axis_tdata[4*CRD_W+ADDR_W +: WORD_W]),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_ent   (fq_ent)
  );

  // hold classified words between front and sequencer
  snz_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_ent    (fq_ent),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_ent   (qb_ent)
  );

  // back: table writes, hash chains per corner, falloff sum, scale and saturate
  snz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_ent    (qb_ent),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (noise_value)
  );

  assign m_axis_tdata = OUT_TDATA_W'(noise_value);

endmodule

FILE: src/snz_check.sv
module snz_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [snz_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]                      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [snz_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import snz_pkg::*;

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[OUT_W-1:0]) <= 18'sd65536) &&
                      ($signed(m_axis_tdata[OUT_W-1:0]) >= -18'sd65536))
    else $error("noise value outside saturation range");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0)
    else $error("result pad bits not zero");

endmodule

bind simplex_noise_2d_3d_4d_top snz_check u_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
